// ===== sv/wmf_pkg.sv =====
package wmf_pkg;

    // Geometry of the filter.
    localparam int NUM_SENSORS  = 10;
    localparam int WINDOW_DEPTH = 8;

    // Field widths.
    localparam int SENSOR_W = 4;
    localparam int DIST_W   = 14;
    localparam int STAMP_W  = 32;

    // Derived storage sizes.
    localparam int SLOT_W      = $clog2(WINDOW_DEPTH);
    localparam int STORE_DEPTH = NUM_SENSORS * WINDOW_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Frame counter saturates at its all-ones value.
    localparam int FRAMES_W   = 5;
    localparam int FRAMES_MAX = 31;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIST_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_ECHO = 1'd1;

    // Register reset values; 12800 is 800.0 cm with four fraction bits.
    localparam logic [FRAMES_W-1:0] WARMUP_RESET  = 5'd19;
    localparam logic [DIST_W-1:0]   NO_ECHO_RESET = 14'd12800;

    // One window entry: a valid flag and a distance.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
    } entry_t;

    // Configuration registers as seen by the controller.
    typedef struct packed {
        logic [FRAMES_W-1:0] warmup_frames;
        logic [DIST_W-1:0]   no_echo_distance;
    } cfg_t;

    // Access request from the controller to the window store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_entry;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    // Each sensor owns a contiguous row of WINDOW_DEPTH entries.
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [SENSOR_W-1:0] sensor,
        input logic [SLOT_W-1:0]   slot
    );
        store_addr = ADDR_W'(ADDR_W'(sensor) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(slot));
    endfunction

endpackage

// ===== sv/wmf_if.sv =====
// Input channel: one range reading per word.
interface wmf_in_if;
    logic                           valid;
    logic                           ready;
    logic [wmf_pkg::SENSOR_W-1:0]   sensor;
    logic [wmf_pkg::DIST_W-1:0]     distance;
    logic                           no_echo;
    logic [wmf_pkg::STAMP_W-1:0]    stamp;

    modport source (output valid, output sensor, output distance, output no_echo,
                    output stamp, input ready);
    modport sink   (input valid, input sensor, input distance, input no_echo,
                    input stamp, output ready);
endinterface

// Output channel: one filtered distance per word.
interface wmf_out_if;
    logic                           valid;
    logic                           ready;
    logic [wmf_pkg::SENSOR_W-1:0]   sensor_out;
    logic [wmf_pkg::DIST_W-1:0]     filtered_distance;
    logic [wmf_pkg::STAMP_W-1:0]    stamp_out;

    modport source (output valid, output sensor_out, output filtered_distance,
                    output stamp_out, input ready);
    modport sink   (input valid, input sensor_out, input filtered_distance,
                    input stamp_out, output ready);
endinterface

// ===== sv/multichannel_window_min_filter.sv =====
// Sliding-window minimum filter for ten range sensors. Each reading it keeps is
// written into its sensor's eight-entry ring in a single window memory, and the
// result is the smallest valid distance in that ring, capped at no_echo_distance.
// The memory has one read port, so a kept reading holds the input through an
// accept, a read of each ring slot and a final compare, and longer while the
// word waits for its consumer beyond the one output register. Readings in
// warm-up frames and readings with an out-of-range sensor index are not kept:
// they are taken without a sweep and give no word. No clearing pass is needed
// after reset: per-entry written flags are cleared by reset. The user must write
// configuration only while the block is idle; the block does not enforce it.
module multichannel_window_min_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    wmf_in_if.sink                            reading,
    wmf_out_if.source                         result
);

    logic [wmf_pkg::FRAMES_W-1:0] warmup_reg, warmup_next;
    logic [wmf_pkg::DIST_W-1:0]   no_echo_reg, no_echo_next;
    wmf_pkg::cfg_t                cfg;
    wmf_pkg::mem_req_t            mem_req;
    wmf_pkg::entry_t              rd_entry;

    // Configuration register writes.
    always_comb
    begin
        warmup_next  = warmup_reg;
        no_echo_next = no_echo_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                wmf_pkg::CFG_WARMUP:  warmup_next  = cfg_data[wmf_pkg::FRAMES_W-1:0];
                wmf_pkg::CFG_NO_ECHO: no_echo_next = cfg_data[wmf_pkg::DIST_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg  <= wmf_pkg::WARMUP_RESET;
            no_echo_reg <= wmf_pkg::NO_ECHO_RESET;
        end
        else
        begin
            warmup_reg  <= warmup_next;
            no_echo_reg <= no_echo_next;
        end
    end

    assign cfg.warmup_frames    = warmup_reg;
    assign cfg.no_echo_distance = no_echo_reg;

    // Sequencer and output register.
    wmf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .reading  (reading),
        .result   (result),
        .mem_req  (mem_req),
        .rd_entry (rd_entry)
    );

    // Window memory for all sensors.
    wmf_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

endmodule

// ===== sv/wmf_store.sv =====
module wmf_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  wmf_pkg::mem_req_t  req,
    output wmf_pkg::entry_t    rd_entry
);

    wmf_pkg::entry_t                   mem [wmf_pkg::STORE_DEPTH];
    logic [wmf_pkg::STORE_DEPTH-1:0]   written_reg;
    logic [wmf_pkg::STORE_DEPTH-1:0]   written_next;
    wmf_pkg::entry_t                   rd_data_reg;
    logic                              rd_written_reg;

    // Entries never written since reset count as invalid.
    always_comb
    begin
        written_next = written_reg;
        if (req.wr_en)
        begin
            written_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

    // Simple dual-port style array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_data_reg    <= mem[req.rd_addr];
            rd_written_reg <= written_reg[req.rd_addr];
        end
    end

    // The stored flag only counts once the entry has been written.
    always_comb
    begin
        rd_entry.valid    = rd_data_reg.valid & rd_written_reg;
        rd_entry.distance = rd_data_reg.distance;
    end

endmodule

// ===== sv/wmf_ctrl.sv =====
module wmf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  wmf_pkg::cfg_t      cfg,
    wmf_in_if.sink             reading,
    wmf_out_if.source          result,
    output wmf_pkg::mem_req_t  mem_req,
    input  wmf_pkg::entry_t    rd_entry
);

    localparam logic [wmf_pkg::SLOT_W-1:0]   LAST_SLOT  = wmf_pkg::SLOT_W'(wmf_pkg::WINDOW_DEPTH - 1);
    localparam logic [wmf_pkg::SENSOR_W-1:0] LAST_SENSOR =
        wmf_pkg::SENSOR_W'(wmf_pkg::NUM_SENSORS - 1);
    localparam logic [wmf_pkg::FRAMES_W-1:0] FRAMES_TOP = wmf_pkg::FRAMES_W'(wmf_pkg::FRAMES_MAX);

    wmf_pkg::state_t                  state_reg, state_next;
    logic [wmf_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [wmf_pkg::SLOT_W-1:0]       k_reg, k_next;
    logic [wmf_pkg::FRAMES_W-1:0]     frames_reg, frames_next;
    logic                             pend_reg, pend_next;
    logic [wmf_pkg::SENSOR_W-1:0]     sensor_reg, sensor_next;
    logic [wmf_pkg::STAMP_W-1:0]      stamp_reg, stamp_next;
    logic [wmf_pkg::DIST_W-1:0]       best_reg, best_next;
    logic                             out_valid_reg, out_valid_next;
    logic [wmf_pkg::SENSOR_W-1:0]     out_sensor_reg, out_sensor_next;
    logic [wmf_pkg::DIST_W-1:0]       out_dist_reg, out_dist_next;
    logic [wmf_pkg::STAMP_W-1:0]      out_stamp_reg, out_stamp_next;

    logic                             accept;
    logic                             in_range;
    logic                             frame_end;
    logic                             dropped;
    logic                             store_en;
    logic                             out_free;
    logic                             load_out;
    logic [wmf_pkg::DIST_W-1:0]       rd_min;
    logic [wmf_pkg::DIST_W-1:0]       best_cur;

    // Classification of the incoming word.
    always_comb
    begin
        accept    = reading.valid & reading.ready;
        in_range  = reading.sensor <= LAST_SENSOR;
        frame_end = reading.sensor == LAST_SENSOR;
        dropped   = frames_reg < cfg.warmup_frames;
        store_en  = accept & in_range & ~dropped;
        out_free  = ~out_valid_reg | result.ready;
    end

    // Running minimum; read data lands in the cycle after its address.
    always_comb
    begin
        rd_min   = (rd_entry.valid && (rd_entry.distance < best_reg)) ?
                   rd_entry.distance : best_reg;
        best_cur = pend_reg ? rd_min : best_reg;
    end

    // The new reading is written on the accept edge and the sweep reads
    // start in the cycle after, so the sweep always sees it without forwarding.
    always_comb
    begin
        mem_req.wr_en    = store_en;
        mem_req.wr_addr  = wmf_pkg::store_addr(reading.sensor, slot_reg);
        mem_req.wr_entry = '{valid: ~reading.no_echo, distance: reading.distance};
        mem_req.rd_en    = state_reg == wmf_pkg::ST_SWEEP;
        mem_req.rd_addr  = wmf_pkg::store_addr(sensor_reg, k_reg);
    end

    // Sequencer: accept, sweep the sensor's row, then hand over the result.
    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        frames_next = frames_reg;
        sensor_next = sensor_reg;
        stamp_next  = stamp_reg;
        best_next   = best_reg;
        pend_next   = state_reg == wmf_pkg::ST_SWEEP;
        load_out    = 1'b0;

        unique case (state_reg)
            wmf_pkg::ST_IDLE:
            begin
                if (accept && in_range)
                begin
                    if (frame_end && (frames_reg != FRAMES_TOP))
                    begin
                        frames_next = frames_reg + 1'b1;
                    end
                    if (!dropped)
                    begin
                        if (frame_end)
                        begin
                            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                        end
                        sensor_next = reading.sensor;
                        stamp_next  = reading.stamp;
                        best_next   = cfg.no_echo_distance;
                        k_next      = '0;
                        state_next  = wmf_pkg::ST_SWEEP;
                    end
                end
            end
            wmf_pkg::ST_SWEEP:
            begin
                best_next = best_cur;
                k_next    = (k_reg == LAST_SLOT) ? '0 : k_reg + 1'b1;
                if (k_reg == LAST_SLOT)
                begin
                    state_next = wmf_pkg::ST_TAIL;
                end
            end
            wmf_pkg::ST_TAIL:
            begin
                best_next = best_cur;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = wmf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = wmf_pkg::ST_HOLD;
                end
            end
            wmf_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = wmf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Output register decouples the sweep from a stalled consumer.
    always_comb
    begin
        out_valid_next  = out_valid_reg & ~result.ready;
        out_sensor_next = out_sensor_reg;
        out_dist_next   = out_dist_reg;
        out_stamp_next  = out_stamp_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_sensor_next = sensor_reg;
            out_dist_next   = best_cur;
            out_stamp_next  = stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmf_pkg::ST_IDLE;
            slot_reg      <= '0;
            k_reg         <= '0;
            frames_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            k_reg         <= k_next;
            frames_reg    <= frames_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sensor_reg     <= sensor_next;
        stamp_reg      <= stamp_next;
        best_reg       <= best_next;
        out_sensor_reg <= out_sensor_next;
        out_dist_reg   <= out_dist_next;
        out_stamp_reg  <= out_stamp_next;
    end

    // Port drive.
    assign reading.ready            = state_reg == wmf_pkg::ST_IDLE;
    assign result.valid             = out_valid_reg;
    assign result.sensor_out        = out_sensor_reg;
    assign result.filtered_distance = out_dist_reg;
    assign result.stamp_out         = out_stamp_reg;

endmodule

// ===== sv/wmf_checker.sv =====
module wmf_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [wmf_pkg::SENSOR_W-1:0]      in_sensor,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [wmf_pkg::SENSOR_W-1:0]      out_sensor,
    input  logic [wmf_pkg::DIST_W-1:0]        out_dist,
    input  logic [wmf_pkg::STAMP_W-1:0]       out_stamp
);

    localparam logic [wmf_pkg::SENSOR_W-1:0] SENSOR_LIMIT = wmf_pkg::SENSOR_W'(wmf_pkg::NUM_SENSORS);

    logic in_acc;

    assign in_acc = in_valid & in_ready;

    // A stalled output word holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sensor) && $stable(out_dist)
            && $stable(out_stamp))
        else $error("output word changed while stalled");

    // Every result names a real sensor.
    a_out_sensor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_sensor < SENSOR_LIMIT)
        else $error("result for an out-of-range sensor");

    // A reading for an unknown sensor is discarded at once.
    a_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_sensor >= SENSOR_LIMIT) |=> in_ready)
        else $error("out-of-range reading occupied the filter");

    // Once a window sweep starts, it is not over at its first busy cycle.
    a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 !in_ready |=> !in_ready)
        else $error("window sweep ended too early");

endmodule

bind multichannel_window_min_filter wmf_checker u_wmf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (reading.valid),
    .in_ready   (reading.ready),
    .in_sensor  (reading.sensor),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_sensor (result.sensor_out),
    .out_dist   (result.filtered_distance),
    .out_stamp  (result.stamp_out)
);
